FILE: design/sha_pkg.sv
// SHA-256 byte hasher package: payload structs, state enum, round constants
// and round helper functions. No dependencies.
package sha_pkg;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
  } sha_in_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [1:0]  word_index;
    logic        digest_last;
  } sha_out_t;

  localparam logic REQ_ABSORB = 1'b0;
  localparam logic REQ_FINISH = 1'b1;

  localparam int BlockWords = 16;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_EMIT
  } sha_state_t;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    round_k = k[i];
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] i);
    case (i)
      3'd0: init_h = 32'h6a09e667;
      3'd1: init_h = 32'hbb67ae85;
      3'd2: init_h = 32'h3c6ef372;
      3'd3: init_h = 32'ha54ff53a;
      3'd4: init_h = 32'h510e527f;
      3'd5: init_h = 32'h9b05688c;
      3'd6: init_h = 32'h1f83d9ab;
      default: init_h = 32'h5be0cd19;
    endcase
  endfunction

endpackage

FILE: design/sha256_byte_stream_hasher.sv
// Top level of the SHA-256 byte hasher: handshake, block buffer RAM,
// padding sequencer. Depends on sha_pkg, sha_ram, sha_round.
//
//   channel | direction | payload    | handshake
//   in_     | input     | sha_in_t   | in_valid / in_ready
//   out_    | output    | sha_out_t  | out_valid / out_ready
//
// The 64th byte of a block starts the block load (RAM read, then 16 words),
// the rounds and the add step. A finish item writes one padding word per
// cycle from the mark word to word 15, runs the block, repeats with 16
// padding words when the length spills into a second block, then sends four
// output items. Reset is synchronous; no item is taken while a block is
// compressed or a digest is out. Output stalls hold the digest word.
module sha256_byte_stream_hasher import sha_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  sha_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output sha_out_t out_data
);
  sha_state_t state_r, state_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] len_r, len_nxt;
  logic [6:0]  cnt_r, cnt_nxt;     // load/round counter, word pointer in padding
  logic        fin_r, fin_nxt;     // finishing message
  logic        last_r, last_nxt;   // this block is the final padded one
  logic        mark_r, mark_nxt;   // mark word still to be written
  logic [1:0]  oidx_r, oidx_nxt;
  logic [23:0] part_r, part_nxt;   // three bytes gathered into a word

  logic        we;
  logic [3:0]  waddr, raddr;
  logic [31:0] wdata, rdata;
  logic [63:0] digest_q;
  logic        acc, init_hash, start_blk, load_w, do_round, add_hash;

  sha_ram #(.Width(32), .Depth(BlockWords)) u_blk (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  sha_round u_round (
    .clk, .rst_n, .init_hash, .start_blk, .load_w, .w_in(rdata),
    .do_round, .round_idx(cnt_r[5:0]), .add_hash, .sel_word(oidx_r),
    .digest_q(digest_q)
  );

  assign acc = in_valid && in_ready;
  assign out_data = '{digest_word: digest_q, word_index: oidx_r,
                      digest_last: (oidx_r == 2'd3)};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc && in_data.req_type == REQ_FINISH) state_nxt = ST_PAD;
        else if (acc && fill_r == 6'd63) state_nxt = ST_LOAD;
      end
      ST_PAD:   if (cnt_r[3:0] == 4'd15) state_nxt = ST_LOAD;
      ST_LOAD:  if (cnt_r == 7'd16) state_nxt = ST_ROUND;
      ST_ROUND: if (cnt_r == 7'd63) state_nxt = ST_ADD;
      ST_ADD: begin
        if (!fin_r) state_nxt = ST_IDLE;
        else if (last_r) state_nxt = ST_EMIT;
        else state_nxt = ST_PAD;
      end
      ST_EMIT:  if (out_ready && oidx_r == 2'd3) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    out_valid = (state_r == ST_EMIT);
    fill_nxt = fill_r; len_nxt = len_r; cnt_nxt = cnt_r; fin_nxt = fin_r;
    last_nxt = last_r; mark_nxt = mark_r; oidx_nxt = oidx_r; part_nxt = part_r;
    we = 1'b0; waddr = fill_r[5:2]; wdata = {part_r, in_data.data_byte};
    raddr = cnt_r[3:0];
    init_hash = 1'b0; start_blk = 1'b0; load_w = 1'b0;
    do_round = 1'b0; add_hash = 1'b0;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (acc && in_data.req_type == REQ_ABSORB) begin
          fill_nxt = fill_r + 6'd1;
          len_nxt  = len_r + 64'd8;
          part_nxt = {part_r[15:0], in_data.data_byte};
          we = (fill_r[1:0] == 2'd3);
        end else if (acc) begin
          fin_nxt  = 1'b1;
          mark_nxt = 1'b1;
          // length fits behind the mark only when fewer than 56 bytes are held
          last_nxt = (fill_r[5:3] != 3'b111);
          cnt_nxt  = {3'b000, fill_r[5:2]};
        end
      end
      ST_PAD: begin
        // write one word per cycle: mark word, zeros, then in the final block the bit length
        we = 1'b1;
        waddr = cnt_r[3:0];
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r[3:0] == 4'd15) cnt_nxt = '0;
        if (mark_r) begin
          mark_nxt = 1'b0;
          case (fill_r[1:0])
            2'd0: wdata = 32'h8000_0000;
            2'd1: wdata = {part_r[7:0], 24'h80_0000};
            2'd2: wdata = {part_r[15:0], 16'h8000};
            default: wdata = {part_r[23:0], 8'h80};
          endcase
        end else if (last_r && cnt_r[3:0] == 4'd14) begin
          wdata = len_r[63:32];
        end else if (last_r && cnt_r[3:0] == 4'd15) begin
          wdata = len_r[31:0];
        end else begin
          wdata = 32'h0;
        end
      end
      ST_LOAD: begin
        cnt_nxt = cnt_r + 7'd1;
        load_w = (cnt_r != 7'd0);
        if (cnt_r == 7'd16) begin
          start_blk = 1'b1;
          cnt_nxt = '0;
        end
      end
      ST_ROUND: begin
        do_round = 1'b1;
        cnt_nxt = cnt_r + 7'd1;
      end
      ST_ADD: begin
        add_hash = 1'b1;
        fill_nxt = '0;
        oidx_nxt = '0;
        cnt_nxt  = '0;
        // advance to the length-only second block
        if (fin_r && !last_r) last_nxt = 1'b1;
      end
      ST_EMIT: begin
        if (out_ready) begin
          oidx_nxt = oidx_r + 2'd1;
          if (oidx_r == 2'd3) begin
            init_hash = 1'b1;
            fill_nxt = '0; len_nxt = '0; fin_nxt = 1'b0; last_nxt = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r <= '0; len_r <= '0; cnt_r <= '0;
      fin_r <= 1'b0; last_r <= 1'b0; mark_r <= 1'b0; oidx_r <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r <= fill_nxt; len_r <= len_nxt; cnt_r <= cnt_nxt;
      fin_r <= fin_nxt; last_r <= last_nxt; mark_r <= mark_nxt; oidx_r <= oidx_nxt;
    end
    part_r <= part_nxt;
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken during digest output");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) |-> (cnt_r < 7'd64)) else $error("round overrun");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && oidx_r == 2'd3) |=> state_r == ST_IDLE)
    else $error("digest did not end");
endmodule

FILE: design/sha_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module sha_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: design/sha_round.sv
// SHA-256 round datapath: working variables, schedule window, hash words.
// Depends on sha_pkg.
module sha_round import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        init_hash,   // load initial value into hash words
  input  logic        start_blk,   // copy hash words into working vars
  input  logic        load_w,      // shift a fresh schedule word in
  input  logic [31:0] w_in,
  input  logic        do_round,
  input  logic [5:0]  round_idx,
  input  logic        add_hash,
  input  logic [1:0]  sel_word,
  output logic [63:0] digest_q
);
  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [31:0] w_r [16];
  logic [31:0] w_new, w_cur, t1, t2, s0, s1;

  always_comb begin
    s0 = ror(w_r[1], 7) ^ ror(w_r[1], 18) ^ (w_r[1] >> 3);
    s1 = ror(w_r[14], 17) ^ ror(w_r[14], 19) ^ (w_r[14] >> 10);
    w_new = w_r[0] + s0 + w_r[9] + s1;
    w_cur = w_r[0];
    t1 = v_r[7] + (ror(v_r[4], 6) ^ ror(v_r[4], 11) ^ ror(v_r[4], 25)) +
         ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6])) + round_k(round_idx) + w_cur;
    t2 = (ror(v_r[0], 2) ^ ror(v_r[0], 13) ^ ror(v_r[0], 22)) +
         ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
    digest_q = {h_r[{sel_word, 1'b0}], h_r[{sel_word, 1'b1}]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n || init_hash) begin
      for (int i = 0; i < 8; i++) h_r[i] <= init_h(3'(i));
    end else if (add_hash) begin
      for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
    end
    if (start_blk) begin
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end else if (do_round) begin
      v_r[0] <= t1 + t2;
      v_r[1] <= v_r[0];
      v_r[2] <= v_r[1];
      v_r[3] <= v_r[2];
      v_r[4] <= v_r[3] + t1;
      v_r[5] <= v_r[4];
      v_r[6] <= v_r[5];
      v_r[7] <= v_r[6];
    end
    // window holds w[i..i+15] at round i; the oldest word feeds the round
    if (load_w || do_round) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i + 1];
      w_r[15] <= load_w ? w_in : w_new;
    end
  end
endmodule

FILE: test/tb.sv
// Testbench for sha256_byte_stream_hasher: byte-stream messages in, digest words out,
// checked against a SHA-256 predictor kept here. Depends on sha_pkg and the RTL.
module tb import sha_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  sha_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  sha_out_t out_data;

  sha256_byte_stream_hasher DUT (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  localparam logic [31:0] KTAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
  localparam logic [31:0] HINIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  // predictor state
  logic [31:0] hw [8];
  logic [7:0]  blk [64];
  logic [5:0]  fill;
  logic [63:0] msg_bits;

  sha_in_t  pending_items[$];
  sha_out_t digest_expect[$];
  int       errors = 0;
  int       digests_seen = 0;
  int       two_block_pads = 0;
  bit       hold_off = 1'b0;

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + w[i-7]
           + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
           + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
    v = hw;
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTAB[i] + w[i];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hw[i] += v[i];
  endfunction

  function automatic void restart_message();
    hw = HINIT;
    fill = '0;
    msg_bits = '0;
  endfunction

  function automatic void hash_item(sha_in_t it);
    sha_out_t r;
    int pos;
    if (it.req_type == REQ_ABSORB) begin
      blk[fill] = it.data_byte;
      msg_bits += 64'd8;
      if (fill == 6'd63) compress_block();
      fill = fill + 6'd1;
      return;
    end
    pos = fill;
    blk[pos] = 8'h80;
    pos++;
    if (pos > 56) begin
      two_block_pads++;
      for (int i = pos; i < 64; i++) blk[i] = '0;
      compress_block();
      pos = 0;
    end
    for (int i = pos; i < 56; i++) blk[i] = '0;
    for (int i = 0; i < 8; i++) blk[63-i] = msg_bits[8*i +: 8];
    compress_block();
    for (int k = 0; k < 4; k++) begin
      r.digest_word = {hw[2*k], hw[2*k+1]};
      r.word_index  = k[1:0];
      r.digest_last = (k == 3);
      digest_expect.push_back(r);
    end
    restart_message();
  endfunction

  task automatic add_message(int nbytes, bit all_ff);
    sha_in_t it;
    for (int i = 0; i < nbytes; i++) begin
      it.req_type  = REQ_ABSORB;
      it.data_byte = all_ff ? 8'hff : 8'($urandom);
      pending_items.push_back(it);
    end
    it.req_type  = REQ_FINISH;
    it.data_byte = 8'($urandom);
    pending_items.push_back(it);
  endtask

  // sender: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        hash_item(in_data);
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_valid <= 1'b1;
          in_data  <= pending_items.pop_front();
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 40);
            if ($urandom_range(0, 2) == 0) gap_left <= $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: own stall pattern, with one long hold-off
  int stall_mode = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
      if (hold_off) out_ready <= 1'b0;
      else if (stall_mode == 0) out_ready <= 1'b1;
      else if (stall_mode == 1) out_ready <= ($urandom_range(0, 3) != 0);
      else out_ready <= ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    wait (digests_seen >= 2);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (600) @(posedge clk);
    hold_off <= 1'b0;
  end

  // monitor
  always @(posedge clk) begin
    sha_out_t e;
    if (rst_n && out_valid && out_ready) begin
      if (digest_expect.size() == 0) begin
        $display("%0t: unexpected digest word %h idx %0d last %0b", $time,
                 out_data.digest_word, out_data.word_index, out_data.digest_last);
        errors++;
      end else begin
        e = digest_expect.pop_front();
        if (out_data.digest_word !== e.digest_word) begin
          $display("%0t: digest_word expected %h got %h", $time,
                   e.digest_word, out_data.digest_word);
          errors++;
        end
        if (out_data.word_index !== e.word_index) begin
          $display("%0t: word_index expected %0d got %0d", $time,
                   e.word_index, out_data.word_index);
          errors++;
        end
        if (out_data.digest_last !== e.digest_last) begin
          $display("%0t: digest_last expected %0b got %0b", $time,
                   e.digest_last, out_data.digest_last);
          errors++;
        end
        if (e.digest_last) digests_seen++;
      end
    end
  end

  // cycle limit
  int cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int nb;
    restart_message();
    // directed: empty, one byte, all-ones byte, five bytes, a single zero byte
    add_message(0, 1'b0);
    add_message(1, 1'b0);
    add_message(1, 1'b1);
    add_message(0, 1'b0);
    add_message(5, 1'b0);
    pending_items.push_back('{req_type: REQ_ABSORB, data_byte: 8'h00});
    pending_items.push_back('{req_type: REQ_FINISH, data_byte: 8'hff});
    // directed pad boundaries and exact block, then random: mostly short messages, some crossing the padding boundary
    add_message(55, 1'b0);
    add_message(56, 1'b0);
    add_message(63, 1'b0);
    add_message(64, 1'b0);
    while (pending_items.size() < 500) begin
      case ($urandom_range(0, 3))
        0: nb = $urandom_range(0, 8);
        1: nb = $urandom_range(50, 70);
        2: nb = $urandom_range(0, 130);
        default: nb = $urandom_range(0, 30);
      endcase
      add_message(nb, ($urandom_range(0, 15) == 0));
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_items.size() == 0);
    @(posedge clk);
    while (in_valid || digest_expect.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d digests, %0d with padding in a second block,", digests_seen,
             two_block_pads);
    $display("including empty, block-boundary and long receiver stall cases");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
